// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// clocked assertion, disabled while reset is active
`define ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion, checked at every rising edge
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_RST(lbl, clk, rstn, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== rtl/lbs_pkg.sv =====
package lbs_pkg;

    // field widths
    localparam int CMD_W   = 2;
    localparam int INDEX_W = 10;
    localparam int KEY_W   = 16;
    localparam int CNT_W   = 11;
    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 16;

    // command codes
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOWER = 2'd1;
    localparam logic [CMD_W-1:0] CMD_UPPER = 2'd2;

    // one table entry or search key, x most significant in the order (z in the top bits)
    typedef struct packed {
        logic signed [KEY_W-1:0] z;
        logic signed [KEY_W-1:0] y;
        logic signed [KEY_W-1:0] x;
    } key3_t;

    // controller to datapath
    typedef struct packed {
        logic load_write;
        logic load_query;
        logic read_issue;
        logic step;
        logic out_load;
    } lbs_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic n_zero;
        logic step_last;
    } lbs_status_t;

endpackage

// ===== rtl/lexicographic_bound_search.sv =====
// channel  dir  signals                     content (lowest bit up)
// s        in   s_tvalid s_tready s_tdata   entry_index, key_x, key_y, key_z
//               s_tuser                     cmd
// m        out  m_tvalid m_tready m_tdata   bound_index
// cfg      in   cfg_wr_en cfg_wr_data       entry_count
//
// write and ignored items are accepted in idle and leave the controller idle
// a query is accepted, then takes one read and one compare per halving step, and
// then loads the result into the output register
// one item is in work at a time; the table read port sets the step rate
// reset clears the controller and entry_count, the table is not cleared
// a result waits in the output register and stalls only the next query's finish
module lexicographic_bound_search #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [lbs_pkg::CNT_W-1:0]        cfg_wr_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // entry_index[9:0], key_x[25:10], key_y[41:26], key_z[57:42], zeros above
    input  logic [lbs_pkg::S_DATA_W-1:0]     s_tdata,
    // cmd[1:0]
    input  logic [lbs_pkg::CMD_W-1:0]        s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // bound_index[10:0], zeros above
    output logic [lbs_pkg::M_DATA_W-1:0]     m_tdata
);

    lbs_pkg::lbs_cmd_t           dp_cmd;
    lbs_pkg::lbs_status_t        status;
    lbs_pkg::key3_t              s_key;
    logic [lbs_pkg::INDEX_W-1:0] entry_index;
    logic [lbs_pkg::CNT_W-1:0]   bound_index;

    // unpack input item
    assign entry_index = s_tdata[9:0];
    assign s_key.x     = s_tdata[25:10];
    assign s_key.y     = s_tdata[41:26];
    assign s_key.z     = s_tdata[57:42];

    lbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_cmd    (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .dp_cmd   (dp_cmd)
    );

    lbs_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_cmd       (s_tuser),
        .entry_index (entry_index),
        .s_key       (s_key),
        .dp_cmd      (dp_cmd),
        .status      (status),
        .bound_index (bound_index)
    );

    // pack result item
    assign m_tdata = lbs_pkg::M_DATA_W'(bound_index);

endmodule

// ===== rtl/lbs_ctrl.sv =====
`include "assert_macros.svh"

module lbs_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [lbs_pkg::CMD_W-1:0] s_cmd,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    input  lbs_pkg::lbs_status_t      status,
    output lbs_pkg::lbs_cmd_t         dp_cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_ADDR   = 2'd1;
    localparam logic [1:0] ST_CMP    = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       m_tvalid_reg;
    logic       m_tvalid_next;
    logic       accept;
    logic       out_free;

    // handshake and commands
    always_comb
    begin
        s_tready = (state_reg == ST_IDLE);
        accept   = s_tvalid && s_tready;
        out_free = !m_tvalid_reg || m_tready;
        dp_cmd.load_write = accept && (s_cmd == lbs_pkg::CMD_WRITE);
        dp_cmd.load_query = accept &&
                            ((s_cmd == lbs_pkg::CMD_LOWER) || (s_cmd == lbs_pkg::CMD_UPPER));
        dp_cmd.read_issue = (state_reg == ST_ADDR);
        dp_cmd.step       = (state_reg == ST_CMP);
        dp_cmd.out_load   = (state_reg == ST_FINISH) && out_free;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (dp_cmd.load_query)
                begin
                    state_next = status.n_zero ? ST_FINISH : ST_ADDR;
                end
            end
            ST_ADDR:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                state_next = status.step_last ? ST_FINISH : ST_ADDR;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result valid flag
    always_comb
    begin
        if (dp_cmd.out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    `ASSERT_RST(a_addr_then_cmp, clk, rst_n,
        (state_reg == ST_ADDR) |=> (state_reg == ST_CMP),
        "read issue not followed by compare")
    `ASSERT_RST(a_finish_delivers, clk, rst_n,
        (state_reg == ST_FINISH) && out_free |=> m_tvalid_reg && (state_reg == ST_IDLE),
        "finished search did not present its item")

endmodule

// ===== rtl/lbs_datapath.sv =====
`include "assert_macros.svh"

module lbs_datapath #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [lbs_pkg::CNT_W-1:0]    cfg_wr_data,
    input  logic [lbs_pkg::CMD_W-1:0]    s_cmd,
    input  logic [lbs_pkg::INDEX_W-1:0]  entry_index,
    input  lbs_pkg::key3_t               s_key,
    input  lbs_pkg::lbs_cmd_t            dp_cmd,
    output lbs_pkg::lbs_status_t         status,
    output logic [lbs_pkg::CNT_W-1:0]    bound_index
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    lbs_pkg::key3_t mem [TABLE_DEPTH];

    logic [lbs_pkg::CNT_W-1:0] entry_count_reg;
    logic [lbs_pkg::CNT_W-1:0] n_sat;
    logic [lbs_pkg::CNT_W-1:0] n_reg;
    logic [lbs_pkg::CNT_W-1:0] first_reg;
    logic [lbs_pkg::CNT_W-1:0] first_next;
    logic [lbs_pkg::CNT_W-1:0] count_reg;
    logic [lbs_pkg::CNT_W-1:0] count_next;
    logic [lbs_pkg::CNT_W-1:0] half;
    logic [lbs_pkg::CNT_W-1:0] mid;
    logic [lbs_pkg::CNT_W-1:0] bound_reg;
    lbs_pkg::key3_t            key_reg;
    lbs_pkg::key3_t            rd_data_reg;
    logic                      upper_reg;
    logic                      slot_ok;
    logic                      less;
    logic                      equal;
    logic                      go_right;

    // search count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            entry_count_reg <= cfg_wr_data;
        end
    end

    // count limited to the table size
    always_comb
    begin
        if (32'(entry_count_reg) > TABLE_DEPTH)
        begin
            n_sat = lbs_pkg::CNT_W'(TABLE_DEPTH);
        end
        else
        begin
            n_sat = entry_count_reg;
        end
        slot_ok = (32'(entry_index) < TABLE_DEPTH);
    end

    // table write port and registered read port
    always_ff @(posedge clk)
    begin
        if (dp_cmd.load_write && slot_ok)
        begin
            mem[AW'(entry_index)] <= s_key;
        end
        if (dp_cmd.read_issue)
        begin
            rd_data_reg <= mem[AW'(mid)];
        end
    end

    // lexicographic compare of entry against key
    always_comb
    begin
        half  = count_reg >> 1;
        mid   = first_reg + half;
        equal = (rd_data_reg.x == key_reg.x) && (rd_data_reg.y == key_reg.y) &&
                (rd_data_reg.z == key_reg.z);
        less  = ($signed(rd_data_reg.x) < $signed(key_reg.x)) ||
                ((rd_data_reg.x == key_reg.x) &&
                 (($signed(rd_data_reg.y) < $signed(key_reg.y)) ||
                  ((rd_data_reg.y == key_reg.y) &&
                   ($signed(rd_data_reg.z) < $signed(key_reg.z)))));
        go_right = upper_reg ? (less || equal) : less;
    end

    // halving step
    always_comb
    begin
        first_next = first_reg;
        count_next = count_reg;
        if (dp_cmd.load_query)
        begin
            first_next = '0;
            count_next = n_sat;
        end
        else if (dp_cmd.step)
        begin
            if (go_right)
            begin
                first_next = mid + lbs_pkg::CNT_W'(1);
                count_next = count_reg - half - lbs_pkg::CNT_W'(1);
            end
            else
            begin
                count_next = half;
            end
        end
    end

    assign status.n_zero    = (n_sat == '0);
    assign status.step_last = (count_next == '0);

    // search state and result
    always_ff @(posedge clk)
    begin
        first_reg <= first_next;
        count_reg <= count_next;
        if (dp_cmd.load_query)
        begin
            key_reg   <= s_key;
            upper_reg <= (s_cmd == lbs_pkg::CMD_UPPER);
            n_reg     <= n_sat;
        end
        if (dp_cmd.out_load)
        begin
            bound_reg <= first_reg;
        end
    end

    assign bound_index = bound_reg;

    `ASSERT_RST(a_step_shrinks, clk, rst_n,
        dp_cmd.step |=> (count_reg < $past(count_reg)),
        "search step did not shrink the range")
    `ASSERT_RST(a_range_in_bounds, clk, rst_n,
        dp_cmd.step |-> ((12'(first_reg) + 12'(count_reg)) <= 12'(n_reg)),
        "search range runs past the entry count")

endmodule

// ===== tb/sv/lexicographic_bound_search_tb.sv =====
module lexicographic_bound_search_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH          = 1024;
    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 4;
    localparam int SETTLE_CYCLES  = 40;
    localparam int HOLD_CYCLES    = 400;
    localparam int HOLD_AT_QUERY  = 40;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 740;
    localparam int LOAD_MAX       = 48;

    // the one command code the block ignores
    localparam logic [lbs_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam lbs_pkg::key3_t KEY_LO   = {3{16'h8000}};
    localparam lbs_pkg::key3_t KEY_HI   = {3{16'h7fff}};
    localparam lbs_pkg::key3_t KEY_ZERO = '0;

    typedef enum logic { ROW_ITEM, ROW_CONFIG } row_kind_t;

    // value is the typed bound for a query row, the new count for a config row
    typedef struct {
        row_kind_t                 kind;
        logic [lbs_pkg::CMD_W-1:0] cmd;
        logic [9:0]                slot;
        lbs_pkg::key3_t            key;
        bit                        typed;
        logic [10:0]               value;
    } dir_row_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_wr_en = 1'b0;
    logic [lbs_pkg::CNT_W-1:0]    cfg_wr_data = '0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [lbs_pkg::S_DATA_W-1:0] s_tdata = '0;
    logic [lbs_pkg::CMD_W-1:0]    s_tuser = '0;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [lbs_pkg::M_DATA_W-1:0] m_tdata;

    // predictor state
    lbs_pkg::key3_t entry_table [DEPTH];
    bit             written [DEPTH];
    int unsigned    entry_count_q = 0;

    logic [10:0] pending_bounds[$];
    dir_row_t    dir_rows[$];
    int          error_count = 0;
    int          items_sent = 0;
    int          queries_sent = 0;
    int          stalled_cycles = 0;
    bit          sender_burst = 1'b0;
    bit          hold_req = 1'b0;

    lexicographic_bound_search #(
        .TABLE_DEPTH(DEPTH)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    always #CLK_HALF clk = ~clk;

    // lexicographic order, x most significant, signed fields
    function automatic int lex_compare(lbs_pkg::key3_t a, lbs_pkg::key3_t b);
        if (a.x != b.x) return (a.x < b.x) ? -1 : 1;
        if (a.y != b.y) return (a.y < b.y) ? -1 : 1;
        if (a.z != b.z) return (a.z < b.z) ? -1 : 1;
        return 0;
    endfunction

    // halving search over the covered slots, count saturated to the depth
    function automatic logic [10:0] bound_search(lbs_pkg::key3_t key, bit upper);
        int unsigned first;
        int unsigned span;
        int unsigned half;
        int unsigned mid;
        int          order;
        span = (entry_count_q > DEPTH) ? DEPTH : entry_count_q;
        first = 0;
        while (span > 0)
        begin
            half = span / 2;
            mid = first + half;
            order = lex_compare(entry_table[mid], key);
            if (upper ? (order <= 0) : (order < 0))
            begin
                first = mid + 1;
                span -= half + 1;
            end
            else
            begin
                span = half;
            end
        end
        return first[10:0];
    endfunction

    // update the table copy and tell whether the item yields a bound
    function automatic bit predict_item(logic [lbs_pkg::CMD_W-1:0] cmd, logic [9:0] slot,
                                        lbs_pkg::key3_t key, output logic [10:0] bound);
        bound = '0;
        case (cmd)
            lbs_pkg::CMD_WRITE:
            begin
                entry_table[slot] = key;
                written[slot] = 1'b1;
                return 1'b0;
            end
            lbs_pkg::CMD_LOWER:
            begin
                bound = bound_search(key, 1'b0);
                return 1'b1;
            end
            lbs_pkg::CMD_UPPER:
            begin
                bound = bound_search(key, 1'b1);
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // field values clustered around zero and the extremes, so ties are common
    function automatic logic signed [lbs_pkg::KEY_W-1:0] pick_field();
        int unsigned r;
        r = $urandom_range(0, 9);
        case (r)
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2, 3, 4: return lbs_pkg::KEY_W'($urandom_range(0, 4)) - 16'sd2;
            default: return lbs_pkg::KEY_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic lbs_pkg::key3_t random_key();
        lbs_pkg::key3_t k;
        k.x = pick_field();
        k.y = pick_field();
        k.z = pick_field();
        return k;
    endfunction

    // keys that land on, next to, or away from the covered entries
    function automatic lbs_pkg::key3_t probe_key(int unsigned span);
        lbs_pkg::key3_t k;
        int unsigned    r;
        r = $urandom_range(0, 9);
        if (span == 0 && r < 7)
            r = 9;
        if (r < 7)
            k = entry_table[$urandom_range(0, span - 1)];
        case (r)
            4, 5: k.z = $urandom_range(0, 1) ? k.z + 16'sd1 : k.z - 16'sd1;
            6:    k.y = $urandom_range(0, 1) ? k.y + 16'sd1 : k.y - 16'sd1;
            7:    k = random_key();
            8:    k = $urandom_range(0, 1) ? KEY_HI : KEY_LO;
            9:
            begin
                k.x = lbs_pkg::KEY_W'($urandom_range(0, 65535));
                k.y = lbs_pkg::KEY_W'($urandom_range(0, 65535));
                k.z = lbs_pkg::KEY_W'($urandom_range(0, 65535));
            end
            default: ;
        endcase
        return k;
    endfunction

    // keys on, next to or away from the one value held along both halving paths
    function automatic lbs_pkg::key3_t path_key();
        lbs_pkg::key3_t k;
        k = entry_table[DEPTH / 2];
        case ($urandom_range(0, 5))
            0: k.z = k.z + 16'sd1;
            1: k.z = k.z - 16'sd1;
            2: k = random_key();
            3: k = KEY_HI;
            4: k = KEY_LO;
            default: ;
        endcase
        return k;
    endfunction

    function automatic void add_row(row_kind_t kind, logic [lbs_pkg::CMD_W-1:0] cmd,
                                    logic [9:0] slot, lbs_pkg::key3_t key, bit typed,
                                    logic [10:0] value);
        dir_row_t row;
        row.kind = kind;
        row.cmd = cmd;
        row.slot = slot;
        row.key = key;
        row.typed = typed;
        row.value = value;
        dir_rows.push_back(row);
    endfunction

    // the long receiver hold-off starts at one fixed query
    function automatic void note_query();
        queries_sent++;
        if (queries_sent == HOLD_AT_QUERY)
            hold_req = 1'b1;
    endfunction

    task automatic report_mismatch(string what, logic [lbs_pkg::M_DATA_W-1:0] exp_val,
                                   logic [lbs_pkg::M_DATA_W-1:0] got_val);
        $display("ERROR %0t: %s, expected %0d, got %0d", $realtime, what, exp_val, got_val);
        error_count++;
    endtask

    // offer one item after a random gap and hold it until accepted
    task automatic send_item(logic [lbs_pkg::CMD_W-1:0] cmd, logic [9:0] slot,
                             lbs_pkg::key3_t key, bit typed, logic [10:0] typed_bound);
        int          gap;
        bit          has_bound;
        logic [10:0] bound;
        gap = sender_burst ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {6'b0, key, slot};
        do @(posedge clk); while (!s_tready);
        has_bound = predict_item(cmd, slot, key, bound);
        if (has_bound)
            pending_bounds.push_back(typed ? typed_bound : bound);
        items_sent++;
    endtask

    // drain the block, let a trailing write settle, then load the count
    task automatic set_entry_count(logic [10:0] count);
        s_tvalid <= 1'b0;
        while (pending_bounds.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= count;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        entry_count_q = count;
    endtask

    // write n random keys in ascending order to slots 0 .. n-1
    task automatic load_sorted(int n);
        lbs_pkg::key3_t pool[$];
        lbs_pkg::key3_t held;
        int             j;
        for (int i = 0; i < n; i++)
            pool.push_back(random_key());
        for (int i = 1; i < n; i++)
        begin
            held = pool[i];
            j = i - 1;
            while (j >= 0 && lex_compare(pool[j], held) > 0)
            begin
                pool[j + 1] = pool[j];
                j--;
            end
            pool[j + 1] = held;
        end
        for (int i = 0; i < n; i++)
            send_item(lbs_pkg::CMD_WRITE, 10'(i), pool[i], 1'b0, '0);
    endtask

    // write one value to every slot on the all-left and all-right halving paths
    // of the full table, so a search over the full depth never leaves them
    task automatic fill_paths(lbs_pkg::key3_t value);
        int unsigned first;
        int unsigned span;
        int unsigned half;
        int unsigned mid;
        for (int side = 0; side < 2; side++)
        begin
            first = 0;
            span = DEPTH;
            while (span > 0)
            begin
                half = span / 2;
                mid = first + half;
                if (side == 0 || mid != DEPTH / 2)
                    send_item(lbs_pkg::CMD_WRITE, 10'(mid), value, 1'b0, '0);
                if (side == 0)
                begin
                    span = half;
                end
                else
                begin
                    first = mid + 1;
                    span -= half + 1;
                end
            end
        end
    endtask

    // bound queries over the path-filled table, with ignored commands mixed in
    task automatic run_path_queries(int num);
        logic [lbs_pkg::CMD_W-1:0] cmd;
        for (int i = 0; i < num; i++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_item(CMD_UNUSED, 10'($urandom_range(0, DEPTH - 1)), random_key(), 1'b0, '0);
            end
            else
            begin
                cmd = $urandom_range(0, 1) ? lbs_pkg::CMD_UPPER : lbs_pkg::CMD_LOWER;
                note_query();
                send_item(cmd, 10'($urandom_range(0, DEPTH - 1)), path_key(), 1'b0, '0);
            end
        end
    endtask

    // mostly bound queries, with ignored commands and stray writes mixed in
    task automatic run_queries(int num);
        int unsigned               span;
        int unsigned               r;
        logic [lbs_pkg::CMD_W-1:0] cmd;
        for (int i = 0; i < num; i++)
        begin
            span = (entry_count_q > DEPTH) ? DEPTH : entry_count_q;
            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                send_item(CMD_UNUSED, 10'($urandom_range(0, DEPTH - 1)), random_key(), 1'b0, '0);
            end
            else if (r < 15)
            begin
                send_item(lbs_pkg::CMD_WRITE, 10'($urandom_range(0, DEPTH - 1)), random_key(),
                          1'b0, '0);
            end
            else
            begin
                cmd = $urandom_range(0, 1) ? lbs_pkg::CMD_UPPER : lbs_pkg::CMD_LOWER;
                note_query();
                send_item(cmd, 10'($urandom_range(0, DEPTH - 1)), probe_key(span), 1'b0, '0);
            end
        end
    endtask

    // result side: random stalls, bursts without stalls, one long hold-off
    initial
    begin
        int stall;
        int burst_left;
        burst_left = 0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                stall = (burst_left > 0) ? 0 : $urandom_range(0, 7);
                if (burst_left > 0)
                    burst_left--;
                else if ($urandom_range(0, 15) == 0)
                    burst_left = $urandom_range(8, 32);
                if (stall > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            if (pending_bounds.size() == 0)
                report_mismatch("bound_index with no query pending", '0, m_tdata);
            else if (m_tdata !== {5'b0, pending_bounds[0]})
                report_mismatch("bound_index", {5'b0, pending_bounds.pop_front()}, m_tdata);
            else
                void'(pending_bounds.pop_front());
        end
    end

    // watchdog on cycles without any accepted item or register write
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
        begin
            stalled_cycles <= 0;
        end
        else if (stalled_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
        begin
            stalled_cycles <= stalled_cycles + 1;
        end
    end

    // stimulus
    initial
    begin
        int          base;
        int unsigned choice;
        int unsigned prefix;
        int          load_n;

        // empty table: every search ends at zero
        add_row(ROW_ITEM, lbs_pkg::CMD_LOWER, 10'd0, KEY_ZERO, 1'b1, 11'd0);
        add_row(ROW_ITEM, lbs_pkg::CMD_UPPER, 10'd1023, KEY_HI, 1'b1, 11'd0);
        add_row(ROW_ITEM, CMD_UNUSED, 10'd512, KEY_HI, 1'b0, '0);
        // eight sorted entries with extremes and a duplicate, plus the top slot
        add_row(ROW_ITEM, lbs_pkg::CMD_WRITE, 10'd0, KEY_LO, 1'b0, '0);
        add_row(ROW_ITEM, lbs_pkg::CMD_WRITE, 10'd1, {16'h7fff, 16'h8000, 16'h8000}, 1'b0, '0);
        add_row(ROW_ITEM, lbs_pkg::CMD_WRITE, 10'd2, {16'h0000, 16'h0000, 16'hffff}, 1'b0, '0);
        add_row(ROW_ITEM, lbs_pkg::CMD_WRITE, 10'd3, KEY_ZERO, 1'b0, '0);
        add_row(ROW_ITEM, lbs_pkg::CMD_WRITE, 10'd4, KEY_ZERO, 1'b0, '0);
        add_row(ROW_ITEM, lbs_pkg::CMD_WRITE, 10'd5, {16'hfffb, 16'h0001, 16'h0000}, 1'b0, '0);
        add_row(ROW_ITEM, lbs_pkg::CMD_WRITE, 10'd6, {16'h0000, 16'h8000, 16'h7fff}, 1'b0, '0);
        add_row(ROW_ITEM, lbs_pkg::CMD_WRITE, 10'd7, KEY_HI, 1'b0, '0);
        add_row(ROW_ITEM, lbs_pkg::CMD_WRITE, 10'd1023, KEY_HI, 1'b0, '0);
        add_row(ROW_CONFIG, lbs_pkg::CMD_WRITE, 10'd0, KEY_ZERO, 1'b0, 11'd8);
        add_row(ROW_ITEM, lbs_pkg::CMD_LOWER, 10'd0, KEY_LO, 1'b1, 11'd0);
        add_row(ROW_ITEM, lbs_pkg::CMD_UPPER, 10'd0, KEY_HI, 1'b1, 11'd8);
        add_row(ROW_ITEM, lbs_pkg::CMD_LOWER, 10'd0, KEY_HI, 1'b1, 11'd7);
        add_row(ROW_ITEM, lbs_pkg::CMD_UPPER, 10'd0, KEY_LO, 1'b1, 11'd1);
        add_row(ROW_ITEM, lbs_pkg::CMD_LOWER, 10'd0, KEY_ZERO, 1'b1, 11'd3);
        add_row(ROW_ITEM, lbs_pkg::CMD_UPPER, 10'd0, KEY_ZERO, 1'b1, 11'd5);
        // break the order: the search still runs its halving steps
        add_row(ROW_ITEM, lbs_pkg::CMD_WRITE, 10'd3, {16'h0000, 16'h0000, 16'h7fff}, 1'b0, '0);
        add_row(ROW_ITEM, lbs_pkg::CMD_LOWER, 10'd0, KEY_ZERO, 1'b0, '0);
        // single covered entry, then none
        add_row(ROW_CONFIG, lbs_pkg::CMD_WRITE, 10'd0, KEY_ZERO, 1'b0, 11'd1);
        add_row(ROW_ITEM, lbs_pkg::CMD_UPPER, 10'd0, KEY_LO, 1'b1, 11'd1);
        add_row(ROW_ITEM, lbs_pkg::CMD_LOWER, 10'd0, KEY_ZERO, 1'b1, 11'd1);
        add_row(ROW_CONFIG, lbs_pkg::CMD_WRITE, 10'd0, KEY_ZERO, 1'b0, 11'd0);
        add_row(ROW_ITEM, lbs_pkg::CMD_LOWER, 10'd0, KEY_HI, 1'b1, 11'd0);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CONFIG)
                set_entry_count(dir_rows[i].value);
            else
                send_item(dir_rows[i].cmd, dir_rows[i].slot, dir_rows[i].key,
                          dir_rows[i].typed, dir_rows[i].value);
        end

        // full-depth searches along both halving paths, counts at and beyond the depth
        fill_paths(random_key());
        set_entry_count(11'(DEPTH));
        run_path_queries(20);
        set_entry_count(11'h7ff);
        run_path_queries(15);
        set_entry_count(11'($urandom_range(DEPTH + 1, 2046)));
        run_path_queries(10);

        // mostly short tables with fresh sorted content
        base = items_sent;
        while (items_sent - base < RANDOM_ITEMS)
        begin
            sender_burst = ($urandom_range(0, 3) == 0);
            choice = $urandom_range(0, 9);
            if (choice == 0)
            begin
                set_entry_count(11'd0);
            end
            else if (choice == 1)
            begin
                prefix = 0;
                while (prefix < DEPTH && written[prefix])
                    prefix++;
                set_entry_count(11'($urandom_range(0, prefix)));
            end
            else
            begin
                load_n = $urandom_range(1, LOAD_MAX);
                load_sorted(load_n);
                set_entry_count(11'($urandom_range(1, load_n)));
            end
            run_queries($urandom_range(6, 24));
        end

        s_tvalid <= 1'b0;
        while (pending_bounds.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
